// ----- rtl/rtmal_pkg.sv -----
// Shared types and constants for the routing table merge, age and lookup block
`timescale 1ns / 1ps
package rtmal_pkg;

  // Table geometry
  localparam int TABLE_ENTRIES = 32;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);

  // Field widths
  localparam int NET_W   = 16;
  localparam int HOPS_W  = 5;
  localparam int NODE_W  = 8;
  localparam int FLAGS_W = 2;
  localparam int AGE_W   = 8;

  // Operation codes
  localparam logic [1:0] OP_MERGE  = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_WRITE  = 2'd3;

  // Flag bit positions
  localparam int FLAG_IP_BIT    = 0;
  localparam int FLAG_ADMIN_BIT = 1;

  // Route kinds reported by lookup
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_IP     = 2'd1;
  localparam logic [1:0] KIND_BRIDGE = 2'd2;
  localparam logic [1:0] KIND_LOCAL  = 2'd3;

  // Protocol limits
  localparam logic [3:0]       TUPLE_HOPS_MAX = 4'd15;
  localparam logic [HOPS_W-1:0] HOPS_UNREACH  = 5'd16;
  localparam logic [AGE_W-1:0]  AGE_MAX       = 8'd255;
  localparam logic [AGE_W-1:0]  BAD_AGE_RESET = 8'd2;

  // One table entry as stored in the entry memory
  typedef struct packed {
    logic [NET_W-1:0]   net;
    logic [HOPS_W-1:0]  hops;
    logic [NODE_W-1:0]  node;
    logic [FLAGS_W-1:0] flags;
    logic [AGE_W-1:0]   age;
  } entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic scan;
    logic apply;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_last;
  } ctrl_sts_t;

endpackage

// ----- rtl/rtmal_ctrl.sv -----
// Controller state machine sequencing capture, table scan and final update
`timescale 1ns / 1ps
module rtmal_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [1:0]            operation,
  input  rtmal_pkg::ctrl_sts_t  sts,
  output rtmal_pkg::ctrl_cmd_t  cmd,
  output logic                  busy
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_APPLY = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // Next state and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = (operation == rtmal_pkg::OP_WRITE) ? ST_APPLY : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      // last read entry is evaluated here
      ST_DRAIN: begin
        state_next = ST_APPLY;
      end
      ST_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

// ----- rtl/rtmal_datapath.sv -----
// Datapath: entry memory, valid bits, scan pipeline, merge/age/lookup/write logic
`timescale 1ns / 1ps
module rtmal_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  rtmal_pkg::ctrl_cmd_t  cmd,
  output rtmal_pkg::ctrl_sts_t  sts,
  input  logic                  cfg_valid,
  input  logic [7:0]            cfg_data,
  input  logic [1:0]            operation,
  input  logic [15:0]           net,
  input  logic [3:0]            hops,
  input  logic [7:0]            node,
  input  logic [1:0]            flags,
  input  logic [4:0]            slot,
  input  logic                  last_tuple,
  output logic                  done,
  output logic [1:0]            route_kind,
  output logic [7:0]            next_hop,
  output logic                  table_full,
  output logic                  batch_done
);

  localparam int N = rtmal_pkg::TABLE_ENTRIES;
  localparam int W = rtmal_pkg::IDX_W;

  // Captured transaction
  logic [1:0]  op_q;
  logic [15:0] net_q;
  logic [3:0]  hops_q;
  logic [7:0]  node_q;
  logic [1:0]  flags_q;
  logic [4:0]  slot_q;
  logic        last_q;

  logic [7:0] bad_age;

  // Entry memory and per-entry valid bits
  rtmal_pkg::entry_t mem [N];
  rtmal_pkg::entry_t rd_q;
  logic [N-1:0]      valid;

  // Scan pipeline
  logic [W-1:0] cnt;
  logic         proc_vld;
  logic [W-1:0] proc_idx;

  // Search results
  logic              found;
  logic [W-1:0]      match_idx;
  rtmal_pkg::entry_t match_rec;
  logic              free_found;
  logic [W-1:0]      free_idx;

  // Write port and valid update controls
  logic              wr_en;
  logic [W-1:0]      wr_idx;
  rtmal_pkg::entry_t wr_rec;
  logic              v_set;
  logic              v_clr;
  logic [W-1:0]      v_idx;

  // Result values computed at apply
  logic [1:0] kind_next;
  logic [7:0] hop_next;
  logic       full_next;

  logic [15:0] scan_net;
  logic [4:0]  new_hops;
  logic        slot_ok;
  rtmal_pkg::entry_t new_rec;

  assign sts.scan_last = (cnt == W'(N - 1));
  assign scan_net      = valid[proc_idx] ? rd_q.net : 16'd0;
  assign new_hops      = {1'b0, hops_q} + 5'd1;
  assign slot_ok       = (32'(slot_q) < 32'(N));

  // Freshly learned route record
  always_comb begin
    new_rec       = '0;
    new_rec.net   = net_q;
    new_rec.hops  = new_hops;
    new_rec.node  = node_q;
  end

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      bad_age <= rtmal_pkg::BAD_AGE_RESET;
    end else if (cfg_valid) begin
      bad_age <= cfg_data;
    end
  end

  // Transaction capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= operation;
      net_q   <= net;
      hops_q  <= hops;
      node_q  <= node;
      flags_q <= flags;
      slot_q  <= slot;
      last_q  <= last_tuple;
    end
  end

  // Scan address counter and read pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      proc_vld <= 1'b0;
    end else begin
      proc_vld <= cmd.scan;
      if (cmd.load) begin
        cnt <= '0;
      end else if (cmd.scan) begin
        cnt <= cnt + W'(1);
      end
    end
    proc_idx <= cnt;
  end

  // Memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_rec;
    end
    rd_q <= mem[cnt];
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (v_set) begin
      valid[v_idx] <= 1'b1;
    end else if (v_clr) begin
      valid[v_idx] <= 1'b0;
    end
  end

  // First match and first free slot search
  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if (proc_vld) begin
      if (!found && scan_net != 16'd0 && scan_net == net_q) begin
        found     <= 1'b1;
        match_idx <= proc_idx;
        match_rec <= rd_q;
      end
      if (!free_found && scan_net == 16'd0) begin
        free_found <= 1'b1;
        free_idx   <= proc_idx;
      end
    end
  end

  // Table updates and result values
  always_comb begin
    wr_en     = 1'b0;
    wr_idx    = proc_idx;
    wr_rec    = rd_q;
    v_set     = 1'b0;
    v_clr     = 1'b0;
    v_idx     = proc_idx;
    kind_next = rtmal_pkg::KIND_NONE;
    hop_next  = 8'd0;
    full_next = 1'b0;

    // aging during the scan
    if (proc_vld && op_q == rtmal_pkg::OP_TICK && scan_net != 16'd0 &&
        rd_q.hops != 5'd0 && !rd_q.flags[rtmal_pkg::FLAG_ADMIN_BIT]) begin
      if (rd_q.age >= bad_age) begin
        v_clr = 1'b1;
      end else if (rd_q.age != rtmal_pkg::AGE_MAX) begin
        wr_en      = 1'b1;
        wr_rec.age = rd_q.age + 8'd1;
      end
    end

    if (cmd.apply) begin
      case (op_q)
        rtmal_pkg::OP_WRITE: begin
          if (slot_ok) begin
            wr_en        = 1'b1;
            wr_idx       = W'(slot_q);
            wr_rec.net   = net_q;
            wr_rec.hops  = {1'b0, hops_q};
            wr_rec.node  = node_q;
            wr_rec.flags = flags_q;
            wr_rec.age   = '0;
            v_set        = 1'b1;
            v_idx        = W'(slot_q);
          end
        end
        rtmal_pkg::OP_MERGE: begin
          if (net_q != 16'd0) begin
            if (found) begin
              wr_idx = match_idx;
              v_idx  = match_idx;
              if (match_rec.flags[rtmal_pkg::FLAG_IP_BIT] || match_rec.hops == 5'd0) begin
                // IP and local routes are never overridden
              end else if (hops_q < rtmal_pkg::TUPLE_HOPS_MAX &&
                           (match_rec.age >= bad_age || match_rec.hops >= new_hops)) begin
                wr_en  = 1'b1;
                wr_rec = new_rec;
              end else if (match_rec.node == node_q) begin
                // refresh by the owning router, or drop when unreachable
                if (new_hops < rtmal_pkg::HOPS_UNREACH) begin
                  wr_en       = 1'b1;
                  wr_rec      = match_rec;
                  wr_rec.hops = new_hops;
                  wr_rec.age  = '0;
                end else begin
                  v_clr = 1'b1;
                end
              end
            end else if (free_found) begin
              wr_en  = 1'b1;
              wr_idx = free_idx;
              wr_rec = new_rec;
              v_set  = 1'b1;
              v_idx  = free_idx;
            end else begin
              full_next = 1'b1;
            end
          end
        end
        rtmal_pkg::OP_LOOKUP: begin
          if (found) begin
            if (match_rec.flags[rtmal_pkg::FLAG_IP_BIT]) begin
              kind_next = rtmal_pkg::KIND_IP;
            end else if (match_rec.node != 8'd0) begin
              kind_next = rtmal_pkg::KIND_BRIDGE;
              hop_next  = match_rec.node;
            end else begin
              kind_next = rtmal_pkg::KIND_LOCAL;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result register, strobed for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.apply;
    end
    if (cmd.apply) begin
      route_kind <= kind_next;
      next_hop   <= hop_next;
      table_full <= full_next;
      batch_done <= last_q;
    end
  end

endmodule

// ----- rtl/routing_table_merge_age_lookup_top.sv -----
// Top level of the routing table with route merge, aging and next-hop lookup
`timescale 1ns / 1ps
// A transaction is taken when start is high and busy is low. A write-entry
// transaction goes straight to the apply state. Merge, age tick and lookup
// first sweep the whole entry memory, one entry per cycle, then pass a drain
// state that finishes the last entry read and an apply state that makes the
// update. The result is registered from the apply state.
// Each transaction yields exactly one result, shown for one cycle while done
// is high; the receiver cannot stall it, and a new start may be given in the
// same cycle. bad_age is written through cfg_valid/cfg_data (cfg_ready is
// always high); the user must write it only while no transaction is in flight,
// which the block itself does not enforce. After reset all entries are empty and bad_age is 2.
module routing_table_merge_age_lookup_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [15:0] net,
  input  logic [3:0]  hops,
  input  logic [7:0]  node,
  input  logic [1:0]  flags,
  input  logic [4:0]  slot,
  input  logic        last_tuple,
  output logic        done,
  output logic [1:0]  route_kind,
  output logic [7:0]  next_hop,
  output logic        table_full,
  output logic        batch_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  rtmal_pkg::ctrl_cmd_t cmd;
  rtmal_pkg::ctrl_sts_t sts;
  logic                 cfg_wr;

  // config channel always accepts
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;

  // Sequencer
  rtmal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  // Table and update logic
  rtmal_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_valid  (cfg_wr),
    .cfg_data   (cfg_data),
    .operation  (operation),
    .net        (net),
    .hops       (hops),
    .node       (node),
    .flags      (flags),
    .slot       (slot),
    .last_tuple (last_tuple),
    .done       (done),
    .route_kind (route_kind),
    .next_hop   (next_hop),
    .table_full (table_full),
    .batch_done (batch_done)
  );

endmodule

// ----- bench/routing_table_merge_age_lookup_top_test.sv -----
// Self-checking testbench for the routing table merge, age tick, lookup and write block
`timescale 1ns / 1ps
module routing_table_merge_age_lookup_top_test;
  import rtmal_pkg::*;

  // One command transaction as driven on the input ports
  typedef struct {
    logic [1:0]  op;
    logic [15:0] net;
    logic [3:0]  hops;
    logic [7:0]  node;
    logic [1:0]  flags;
    logic [4:0]  slot;
    logic        last;
  } route_cmd_t;

  // One result as shown while done is high
  typedef struct {
    logic [1:0] kind;
    logic [7:0] next_hop;
    logic       full;
    logic       batch;
  } route_result_t;

  // Shadow routing table plus the queue of results it predicts
  class route_table_scoreboard;
    logic [NET_W-1:0]   tab_net[TABLE_ENTRIES];
    logic [HOPS_W-1:0]  tab_hops[TABLE_ENTRIES];
    logic [NODE_W-1:0]  tab_node[TABLE_ENTRIES];
    logic [FLAGS_W-1:0] tab_flags[TABLE_ENTRIES];
    logic [AGE_W-1:0]   tab_age[TABLE_ENTRIES];
    logic [AGE_W-1:0]   stale_age;
    route_result_t      pending_results[$];
    int                 errors;

    function new();
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        tab_net[i]   = '0;
        tab_hops[i]  = '0;
        tab_node[i]  = '0;
        tab_flags[i] = '0;
        tab_age[i]   = '0;
      end
      stale_age = BAD_AGE_RESET;
      errors = 0;
    endfunction

    function void install(int i, logic [15:0] net, logic [HOPS_W-1:0] hops, logic [7:0] node);
      tab_net[i]   = net;
      tab_hops[i]  = hops;
      tab_node[i]  = node;
      tab_flags[i] = '0;
      tab_age[i]   = '0;
    endfunction

    // Merge one received tuple; returns 1 when the route was dropped for lack of room
    function logic merge_route(logic [15:0] net, logic [3:0] hops, logic [7:0] sender);
      int hit = -1;
      int free_slot = -1;
      logic [HOPS_W-1:0] new_hops;
      new_hops = {1'b0, hops} + 5'd1;
      if (net == 0) return 1'b0;
      for (int i = 0; i < TABLE_ENTRIES && hit < 0; i++) begin
        if (tab_net[i] == 0) begin
          if (free_slot < 0) free_slot = i;
        end else if (tab_net[i] == net) begin
          hit = i;
        end
      end
      if (hit >= 0) begin
        // IP and local routes are never touched by a merge
        if (tab_flags[hit][FLAG_IP_BIT] || tab_hops[hit] == 0) return 1'b0;
        if (hops < TUPLE_HOPS_MAX &&
            (tab_age[hit] >= stale_age || tab_hops[hit] >= new_hops)) begin
          install(hit, net, new_hops, sender);
        end else if (tab_node[hit] == sender) begin
          // owner refresh; unreachable count removes the route
          tab_hops[hit] = new_hops;
          if (new_hops < HOPS_UNREACH) tab_age[hit] = '0;
          else tab_net[hit] = '0;
        end
        return 1'b0;
      end
      if (free_slot < 0) return 1'b1;
      install(free_slot, net, new_hops, sender);
      return 1'b0;
    endfunction

    // Validity tick: age learned routes, drop the stale ones
    function void age_entries();
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (tab_net[i] == 0 || tab_hops[i] == 0 || tab_flags[i][FLAG_ADMIN_BIT]) continue;
        if (tab_age[i] >= stale_age) tab_net[i] = '0;
        else if (tab_age[i] != AGE_MAX) tab_age[i] = tab_age[i] + 8'd1;
      end
    endfunction

    // First matching entry decides how the net is reached
    function void find_route(input logic [15:0] net, output logic [1:0] kind,
                             output logic [7:0] hop);
      kind = KIND_NONE;
      hop  = '0;
      if (net == 0) return;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (tab_net[i] != net) continue;
        if (tab_flags[i][FLAG_IP_BIT]) begin
          kind = KIND_IP;
        end else if (tab_node[i] != 0) begin
          kind = KIND_BRIDGE;
          hop  = tab_node[i];
        end else begin
          kind = KIND_LOCAL;
        end
        return;
      end
    endfunction

    // Accepted transaction: update the table and queue its result
    function void note_command(route_cmd_t c);
      route_result_t r;
      r.kind     = KIND_NONE;
      r.next_hop = '0;
      r.full     = 1'b0;
      r.batch    = c.last;
      case (c.op)
        OP_MERGE:  r.full = merge_route(c.net, c.hops, c.node);
        OP_TICK:   age_entries();
        OP_LOOKUP: find_route(c.net, r.kind, r.next_hop);
        default: begin
          if (c.slot < TABLE_ENTRIES) begin
            tab_net[c.slot]   = c.net;
            tab_hops[c.slot]  = {1'b0, c.hops};
            tab_node[c.slot]  = c.node;
            tab_flags[c.slot] = c.flags;
            tab_age[c.slot]   = '0;
          end
        end
      endcase
      pending_results.push_back(r);
    endfunction

    function void check_result(route_result_t got);
      route_result_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result: route_kind %0d next_hop %0d table_full %0d batch_done %0d",
               got.kind, got.next_hop, got.full, got.batch);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind) begin
        $error("route_kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.next_hop !== want.next_hop) begin
        $error("next_hop: expected %0d, got %0d", want.next_hop, got.next_hop);
        errors++;
      end
      if (got.full !== want.full) begin
        $error("table_full: expected %0d, got %0d", want.full, got.full);
        errors++;
      end
      if (got.batch !== want.batch) begin
        $error("batch_done: expected %0d, got %0d", want.batch, got.batch);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  operation = '0;
  logic [15:0] net = '0;
  logic [3:0]  hops = '0;
  logic [7:0]  node = '0;
  logic [1:0]  flags = '0;
  logic [4:0]  slot = '0;
  logic        last_tuple = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [7:0]  cfg_data = '0;
  logic        busy;
  logic        done;
  logic [1:0]  route_kind;
  logic [7:0]  next_hop;
  logic        table_full;
  logic        batch_done;
  logic        cfg_ready;

  route_table_scoreboard sb;
  route_result_t         seen_result;
  int                    quiet_left = 0;

  routing_table_merge_age_lookup_top dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .operation  (operation),
    .net        (net),
    .hops       (hops),
    .node       (node),
    .flags      (flags),
    .slot       (slot),
    .last_tuple (last_tuple),
    .done       (done),
    .route_kind (route_kind),
    .next_hop   (next_hop),
    .table_full (table_full),
    .batch_done (batch_done),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // Result monitor: done marks a one-cycle result
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      seen_result.kind     = route_kind;
      seen_result.next_hop = next_hop;
      seen_result.full     = table_full;
      seen_result.batch    = batch_done;
      sb.check_result(seen_result);
    end
  end

  // Mostly a small pool of nets so that merges and lookups hit
  function logic [15:0] pick_net();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 16'h0000;
    if (r < 13) return 16'($urandom);
    return 16'($urandom_range(1, 40));
  endfunction

  function logic [7:0] pick_node();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 8'h00;
    if (r < 15) return 8'($urandom);
    return 8'($urandom_range(1, 6));
  endfunction

  function logic [3:0] pick_hops();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 4'd15;
    if (r < 25) return 4'd0;
    return 4'($urandom_range(0, 15));
  endfunction

  function route_cmd_t rand_cmd(logic [1:0] op);
    route_cmd_t c;
    c.op    = op;
    c.net   = pick_net();
    c.hops  = pick_hops();
    c.node  = pick_node();
    c.flags = 2'($urandom_range(0, 3));
    c.slot  = 5'($urandom_range(0, 31));
    c.last  = 1'($urandom_range(0, 1));
    return c;
  endfunction

  function route_cmd_t mk(logic [1:0] op, logic [15:0] n, logic [3:0] h, logic [7:0] nd,
                          logic [1:0] f, logic [4:0] s, logic l);
    route_cmd_t c;
    c.op    = op;
    c.net   = n;
    c.hops  = h;
    c.node  = nd;
    c.flags = f;
    c.slot  = s;
    c.last  = l;
    return c;
  endfunction

  // Idle cycles before the next transaction, with runs of back-to-back traffic
  function int draw_gap();
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet_left = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 7);
  endfunction

  // Drive one command and hold it until the block takes it
  task automatic send_cmd(input route_cmd_t c);
    int gap;
    bit wait_idle;
    gap = draw_gap();
    wait_idle = (quiet_left == 0) && ($urandom_range(0, 3) == 0);
    if (gap > 0 || wait_idle) begin
      start <= 1'b0;
      if (wait_idle) begin
        do @(posedge clk); while (busy !== 1'b0);
      end
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    operation  <= c.op;
    net        <= c.net;
    hops       <= c.hops;
    node       <= c.node;
    flags      <= c.flags;
    slot       <= c.slot;
    last_tuple <= c.last;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_command(c);
  endtask

  // Stop sending and let every outstanding result come back
  task automatic drain();
    start <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_bad_age(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    sb.stale_age = value;
  endtask

  // Random traffic: tuple packets from one sender, ticks, lookups, writes and noise
  task automatic run_phase(input int count, input int merge_pct, input int tick_pct,
                           input int lookup_pct);
    int sent;
    int draw;
    int len;
    logic [7:0] sender;
    route_cmd_t c;
    sent = 0;
    while (sent < count) begin
      draw = $urandom_range(0, 99);
      if (draw < merge_pct) begin
        len = $urandom_range(1, 6);
        sender = pick_node();
        for (int k = 0; k < len; k++) begin
          c = rand_cmd(OP_MERGE);
          c.node = sender;
          if ($urandom_range(0, 9) != 0) c.last = (k == len - 1);
          send_cmd(c);
          sent++;
        end
      end else if (draw < merge_pct + tick_pct) begin
        send_cmd(rand_cmd(OP_TICK));
        sent++;
      end else if (draw < merge_pct + tick_pct + lookup_pct) begin
        send_cmd(rand_cmd(OP_LOOKUP));
        sent++;
      end else begin
        send_cmd(rand_cmd(OP_WRITE));
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, net zero, local/IP entries, hop 15, aging, duplicates
    send_cmd(mk(OP_LOOKUP, 16'h0000, 4'd0,  8'h00, 2'd0, 5'd0,  1'b0));
    send_cmd(mk(OP_MERGE,  16'h0000, 4'd3,  8'h11, 2'd3, 5'd31, 1'b1));
    send_cmd(mk(OP_LOOKUP, 16'h0001, 4'd15, 8'hFF, 2'd3, 5'd31, 1'b0));
    send_cmd(mk(OP_WRITE,  16'hFFFF, 4'd0,  8'h00, 2'd0, 5'd0,  1'b0));
    send_cmd(mk(OP_LOOKUP, 16'hFFFF, 4'd0,  8'h00, 2'd0, 5'd0,  1'b1));
    send_cmd(mk(OP_MERGE,  16'hFFFF, 4'd3,  8'h09, 2'd0, 5'd0,  1'b0));
    send_cmd(mk(OP_WRITE,  16'h8000, 4'd15, 8'hFF, 2'd3, 5'd31, 1'b1));
    send_cmd(mk(OP_LOOKUP, 16'h8000, 4'd0,  8'h00, 2'd0, 5'd0,  1'b0));
    send_cmd(mk(OP_MERGE,  16'h8000, 4'd0,  8'h01, 2'd0, 5'd0,  1'b0));
    send_cmd(mk(OP_MERGE,  16'h0005, 4'd0,  8'hAA, 2'd0, 5'd0,  1'b0));
    send_cmd(mk(OP_LOOKUP, 16'h0005, 4'd0,  8'h00, 2'd0, 5'd0,  1'b0));
    send_cmd(mk(OP_MERGE,  16'h0005, 4'd15, 8'hAA, 2'd0, 5'd0,  1'b1));
    send_cmd(mk(OP_LOOKUP, 16'h0005, 4'd0,  8'h00, 2'd0, 5'd0,  1'b0));
    send_cmd(mk(OP_MERGE,  16'h0006, 4'd15, 8'h55, 2'd0, 5'd0,  1'b0));
    send_cmd(mk(OP_MERGE,  16'h0007, 4'd2,  8'h03, 2'd0, 5'd0,  1'b0));
    send_cmd(mk(OP_MERGE,  16'h0007, 4'd4,  8'h04, 2'd0, 5'd0,  1'b0));
    send_cmd(mk(OP_MERGE,  16'h0007, 4'd1,  8'h04, 2'd0, 5'd0,  1'b1));
    send_cmd(mk(OP_TICK,   16'h0000, 4'd0,  8'h00, 2'd0, 5'd0,  1'b0));
    send_cmd(mk(OP_TICK,   16'h0000, 4'd0,  8'h00, 2'd0, 5'd0,  1'b1));
    send_cmd(mk(OP_TICK,   16'hFFFF, 4'd15, 8'hFF, 2'd3, 5'd31, 1'b0));
    send_cmd(mk(OP_LOOKUP, 16'h0007, 4'd0,  8'h00, 2'd0, 5'd0,  1'b0));
    send_cmd(mk(OP_WRITE,  16'hFFFF, 4'd4,  8'h12, 2'd0, 5'd2,  1'b0));
    send_cmd(mk(OP_WRITE,  16'h0000, 4'd9,  8'h34, 2'd1, 5'd0,  1'b0));
    send_cmd(mk(OP_LOOKUP, 16'hFFFF, 4'd0,  8'h00, 2'd0, 5'd0,  1'b1));
    send_cmd(mk(OP_WRITE,  16'h0000, 4'd0,  8'h00, 2'd0, 5'd2,  1'b0));

    // Random phases over several bad_age settings, including both extremes
    drain();
    write_bad_age(8'd255);
    run_phase(250, 70, 10, 15);
    drain();
    write_bad_age(8'd255);
    run_phase(300, 10, 75, 10);
    drain();
    write_bad_age(8'd1);
    run_phase(250, 45, 20, 25);
    drain();
    write_bad_age(8'd0);
    run_phase(150, 45, 20, 25);
    drain();
    write_bad_age(8'($urandom_range(3, 20)));
    run_phase(250, 50, 15, 25);
    drain();
    write_bad_age(BAD_AGE_RESET);
    run_phase(150, 50, 15, 25);
    drain();
    repeat (40) @(posedge clk);

    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/rtmal_pkg.sv
rtl/rtmal_ctrl.sv
rtl/rtmal_datapath.sv
rtl/routing_table_merge_age_lookup_top.sv
bench/routing_table_merge_age_lookup_top_test.sv
